// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each check is sampled on the rising
// edge of clk. The first form is switched off while rst is high; the second
// form is checked in every cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GNI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GNI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GNI_ASSERT(label, prop, msg)

`define GNI_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/gni_pkg.sv =====
// ----------------------------------------------------------------------------
// gni_pkg: grid neighbour index types and constants
// Widths, codes and types shared by the neighbour index pipeline.
// ----------------------------------------------------------------------------
package gni_pkg;

  localparam int MAX_SIDE = 256;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W   = COORD_W + 1;
  localparam int INDEX_W  = 2 * COORD_W;
  localparam int MAG_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int NUM_DIRS = 4;
  localparam int CFG_W    = SIDE_W;
  localparam int REG_IDX_W = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_WEST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_EAST  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    MODE_PERIODIC = 2'd0,
    MODE_DISSIPATE = 2'd1,
    MODE_WALL     = 2'd2,
    MODE_CIRCULAR = 2'd3
  } mode_t;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOUNDARY_MODE = 2'd2;

  localparam int     RADIUS_RESET = (MAX_SIDE - 1) / 2;
  localparam index_t RSQ4_RESET   = INDEX_W'(4 * RADIUS_RESET * RADIUS_RESET);

  // Configuration as seen by the pipeline. rsq4 is 4*r*r of the circle test.
  typedef struct packed {
    side_t  width;
    side_t  height;
    mode_t  mode;
    index_t rsq4;
  } gni_cfg_t;

  // One neighbour result slot of a cell's burst.
  typedef struct packed {
    logic   valid;
    logic   res;
    dir_t   dir;
    index_t index;
  } gni_slot_t;

  typedef gni_slot_t [NUM_DIRS-1:0] gni_burst_t;

endpackage

// ===== rtl/gni_cell_if.sv =====
// ----------------------------------------------------------------------------
// gni_cell_if: cell coordinate channel
// Valid/ready channel carrying one cell coordinate per request.
// ----------------------------------------------------------------------------
interface gni_cell_if import gni_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t col;
  coord_t row;

  modport source (output valid, output col, output row, input ready);
  modport sink   (input valid, input col, input row, output ready);

endinterface

// ===== rtl/gni_nbr_if.sv =====
// ----------------------------------------------------------------------------
// gni_nbr_if: neighbour result channel
// Valid/ready channel carrying one neighbour result per request.
// ----------------------------------------------------------------------------
interface gni_nbr_if import gni_pkg::*; ();

  logic        valid;
  logic        ready;
  index_t      neighbour_index;
  logic        to_reservoir;
  logic [1:0]  direction;
  logic        last;

  modport source (output valid, output neighbour_index, output to_reservoir,
                  output direction, output last, input ready);
  modport sink   (input valid, input neighbour_index, input to_reservoir,
                  input direction, input last, output ready);

endinterface

// ===== rtl/grid_neighbour_index_unit.sv =====
// ----------------------------------------------------------------------------
// grid_neighbour_index_unit: four-neighbour index generator
// Turns a cell coordinate into its neighbour indices under the boundary mode.
// ----------------------------------------------------------------------------
// Each request on cell_in carries a cell (col,row); the block answers with
// two to four requests on nbr_out, one per neighbour, the final one flagged by
// last. Periodic and circular modes give north, west, south, east; the
// dissipating modes give west, east, north, south, and wall dissipating drops
// the west and north results on the low edges. A reservoir neighbour carries
// index zero. Coordinates are accepted in consecutive cycles, while the
// pipeline has room, into a four-stage pipeline. The single result channel
// sets the sustained rate: each cell holds it for one request per result,
// so cells pass faster where wall dissipating drops a result. The user must
// write configuration registers only while no cell is in flight; the block
// itself does not enforce this.
`include "assert_macros.svh"

module grid_neighbour_index_unit import gni_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  gni_cell_if.sink             cell_in,
  gni_nbr_if.source            nbr_out,
  input  logic                 cfg_write_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  gni_cfg_t   cfg;
  side_t      side_clamped;
  coord_t     radius;
  index_t     radius_sq;
  logic       burst_valid;
  logic       burst_ready;
  gni_burst_t burst;

  // Side registers hold the clamped value: zero acts as one, too large as the
  // maximum side.
  always_comb begin
    if (cfg_data == '0) begin
      side_clamped = side_t'(1);
    end else if (cfg_data > side_t'(MAX_SIDE)) begin
      side_clamped = side_t'(MAX_SIDE);
    end else begin
      side_clamped = cfg_data;
    end
    radius    = COORD_W'((side_clamped - 1'b1) >> 1);
    radius_sq = index_t'(radius) * index_t'(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= side_t'(MAX_SIDE);
      cfg.height <= side_t'(MAX_SIDE);
      cfg.mode   <= MODE_PERIODIC;
      cfg.rsq4   <= RSQ4_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          cfg.width <= side_clamped;
          cfg.rsq4  <= radius_sq << 2;
        end
        REG_GRID_HEIGHT: begin
          cfg.height <= side_clamped;
        end
        REG_BOUNDARY_MODE: begin
          cfg.mode <= mode_t'(cfg_data[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  gni_neigh u_neigh (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .col       (cell_in.col),
    .row       (cell_in.row),
    .out_valid (burst_valid),
    .out_ready (burst_ready),
    .out_burst (burst)
  );

  gni_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .in_valid (burst_valid),
    .in_ready (burst_ready),
    .in_burst (burst),
    .nbr_out  (nbr_out)
  );

  `GNI_ASSERT(a_res_index_zero, nbr_out.valid && nbr_out.to_reservoir |-> nbr_out.neighbour_index == '0, "reservoir result carries a non-zero index")
  `GNI_ASSERT(a_periodic_no_res, nbr_out.valid && cfg.mode == MODE_PERIODIC |-> !nbr_out.to_reservoir, "periodic mode produced a reservoir result")
  `GNI_ASSERT(a_burst_continues, nbr_out.valid && nbr_out.ready && !nbr_out.last |=> nbr_out.valid, "burst broke off before its final result")
  `GNI_ASSERT_ALWAYS(a_reset_idle, rst |=> !nbr_out.valid, "result offered straight after reset")

endmodule

// ===== rtl/gni_neigh.sv =====
// ----------------------------------------------------------------------------
// gni_neigh: neighbour computation pipeline
// Four register stages: coordinate clamp, neighbour coordinates and circle
// offsets, multiplications, then index sums, circle compare and burst build.
// ----------------------------------------------------------------------------
module gni_neigh import gni_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  gni_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  coord_t     col,
  input  coord_t     row,
  output logic       out_valid,
  input  logic       out_ready,
  output gni_burst_t out_burst
);

  // |w-1-2n|, the doubled distance of a cell centre from the grid centre.
  function automatic mag_t centre_mag(side_t wm1, coord_t n);
    logic signed [SIDE_W+1:0] d;
    d = $signed({2'b00, wm1}) - $signed({2'b00, n, 1'b0});
    return d[SIDE_W+1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  function automatic gni_slot_t make_slot(logic valid, logic res, dir_t dir,
                                          index_t idx);
    gni_slot_t s;
    s.valid = valid;
    s.res   = res;
    s.dir   = dir;
    s.index = res ? '0 : idx;
    return s;
  endfunction

  side_t wm1, hm1;
  assign wm1 = cfg.width - 1'b1;
  assign hm1 = cfg.height - 1'b1;

  logic adv1, adv2, adv3, adv4;
  logic s1_valid, s2_valid, s3_valid;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  // Stage 1: clamp the coordinate into the grid.
  coord_t s1_x, s1_y;

  // Stage 2: neighbour coordinates, edge flags and circle offsets.
  coord_t s2_x, s2_xm, s2_xp, s2_y, s2_ym, s2_yp;
  logic [NUM_DIRS-1:0] s2_edge;
  mag_t s2_ax, s2_axm, s2_axp, s2_by, s2_bym, s2_byp;

  // Stage 3: row products and squared offsets.
  coord_t s3_x, s3_xm, s3_xp;
  index_t s3_prod_n, s3_prod_c, s3_prod_s;
  logic [NUM_DIRS-1:0] s3_edge;
  sq_t s3_ax, s3_axm, s3_axp, s3_by, s3_bym, s3_byp;

  coord_t x_next, y_next;
  coord_t xm_next, xp_next, ym_next, yp_next;
  logic [NUM_DIRS-1:0] edge_next;

  always_comb begin
    x_next = ({1'b0, col} >= cfg.width)  ? COORD_W'(wm1) : col;
    y_next = ({1'b0, row} >= cfg.height) ? COORD_W'(hm1) : row;
  end

  always_comb begin
    edge_next = '0;
    edge_next[DIR_WEST]  = (s1_x == '0);
    edge_next[DIR_EAST]  = ({1'b0, s1_x} == wm1);
    edge_next[DIR_NORTH] = (s1_y == '0);
    edge_next[DIR_SOUTH] = ({1'b0, s1_y} == hm1);
    // Wrapped coordinates; beyond an edge they only matter on the torus.
    xm_next = edge_next[DIR_WEST]  ? COORD_W'(wm1) : s1_x - 1'b1;
    xp_next = edge_next[DIR_EAST]  ? '0 : s1_x + 1'b1;
    ym_next = edge_next[DIR_NORTH] ? COORD_W'(hm1) : s1_y - 1'b1;
    yp_next = edge_next[DIR_SOUTH] ? '0 : s1_y + 1'b1;
  end

  index_t idx_n, idx_w, idx_s, idx_e;
  sum_t   sum_n, sum_w, sum_s, sum_e;
  logic [NUM_DIRS-1:0] outside;
  gni_burst_t burst_next;

  always_comb begin
    idx_n = s3_prod_n + index_t'(s3_x);
    idx_w = s3_prod_c + index_t'(s3_xm);
    idx_s = s3_prod_s + index_t'(s3_x);
    idx_e = s3_prod_c + index_t'(s3_xp);
    sum_n = sum_t'(s3_ax)  + sum_t'(s3_bym);
    sum_w = sum_t'(s3_axm) + sum_t'(s3_by);
    sum_s = sum_t'(s3_ax)  + sum_t'(s3_byp);
    sum_e = sum_t'(s3_axp) + sum_t'(s3_by);
    outside = '0;
    outside[DIR_NORTH] = sum_n > sum_t'(cfg.rsq4);
    outside[DIR_WEST]  = sum_w > sum_t'(cfg.rsq4);
    outside[DIR_SOUTH] = sum_s > sum_t'(cfg.rsq4);
    outside[DIR_EAST]  = sum_e > sum_t'(cfg.rsq4);

    case (cfg.mode)
      MODE_PERIODIC: begin
        burst_next[0] = make_slot(1'b1, 1'b0, DIR_NORTH, idx_n);
        burst_next[1] = make_slot(1'b1, 1'b0, DIR_WEST,  idx_w);
        burst_next[2] = make_slot(1'b1, 1'b0, DIR_SOUTH, idx_s);
        burst_next[3] = make_slot(1'b1, 1'b0, DIR_EAST,  idx_e);
      end
      MODE_DISSIPATE: begin
        burst_next[0] = make_slot(1'b1, s3_edge[DIR_WEST],  DIR_WEST,  idx_w);
        burst_next[1] = make_slot(1'b1, s3_edge[DIR_EAST],  DIR_EAST,  idx_e);
        burst_next[2] = make_slot(1'b1, s3_edge[DIR_NORTH], DIR_NORTH, idx_n);
        burst_next[3] = make_slot(1'b1, s3_edge[DIR_SOUTH], DIR_SOUTH, idx_s);
      end
      MODE_WALL: begin
        // The low edges drop their result instead of sending it to the sink.
        burst_next[0] = make_slot(!s3_edge[DIR_WEST], 1'b0, DIR_WEST, idx_w);
        burst_next[1] = make_slot(1'b1, s3_edge[DIR_EAST], DIR_EAST, idx_e);
        burst_next[2] = make_slot(!s3_edge[DIR_NORTH], 1'b0, DIR_NORTH, idx_n);
        burst_next[3] = make_slot(1'b1, s3_edge[DIR_SOUTH], DIR_SOUTH, idx_s);
      end
      default: begin
        burst_next[0] = make_slot(1'b1, s3_edge[DIR_NORTH] || outside[DIR_NORTH],
                                  DIR_NORTH, idx_n);
        burst_next[1] = make_slot(1'b1, s3_edge[DIR_WEST] || outside[DIR_WEST],
                                  DIR_WEST, idx_w);
        burst_next[2] = make_slot(1'b1, s3_edge[DIR_SOUTH] || outside[DIR_SOUTH],
                                  DIR_SOUTH, idx_s);
        burst_next[3] = make_slot(1'b1, s3_edge[DIR_EAST] || outside[DIR_EAST],
                                  DIR_EAST, idx_e);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid  <= in_valid;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) s3_valid  <= s2_valid;
      if (adv4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_x <= x_next;
      s1_y <= y_next;
    end
    if (adv2) begin
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_xm   <= xm_next;
      s2_xp   <= xp_next;
      s2_ym   <= ym_next;
      s2_yp   <= yp_next;
      s2_edge <= edge_next;
      s2_ax   <= centre_mag(wm1, s1_x);
      s2_axm  <= centre_mag(wm1, xm_next);
      s2_axp  <= centre_mag(wm1, xp_next);
      s2_by   <= centre_mag(wm1, s1_y);
      s2_bym  <= centre_mag(wm1, ym_next);
      s2_byp  <= centre_mag(wm1, yp_next);
    end
    if (adv3) begin
      s3_x      <= s2_x;
      s3_xm     <= s2_xm;
      s3_xp     <= s2_xp;
      s3_edge   <= s2_edge;
      s3_prod_n <= index_t'(s2_ym) * index_t'(cfg.width);
      s3_prod_c <= index_t'(s2_y)  * index_t'(cfg.width);
      s3_prod_s <= index_t'(s2_yp) * index_t'(cfg.width);
      s3_ax     <= sq_t'(s2_ax)  * sq_t'(s2_ax);
      s3_axm    <= sq_t'(s2_axm) * sq_t'(s2_axm);
      s3_axp    <= sq_t'(s2_axp) * sq_t'(s2_axp);
      s3_by     <= sq_t'(s2_by)  * sq_t'(s2_by);
      s3_bym    <= sq_t'(s2_bym) * sq_t'(s2_bym);
      s3_byp    <= sq_t'(s2_byp) * sq_t'(s2_byp);
    end
    if (adv4) begin
      out_burst <= burst_next;
    end
  end

endmodule

// ===== rtl/gni_serial.sv =====
// ----------------------------------------------------------------------------
// gni_serial: burst serialiser
// Holds one cell's result slots and sends the valid ones in slot order,
// one request per cycle while nbr_out.ready is high, marking the final one.
// ----------------------------------------------------------------------------
module gni_serial import gni_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  gni_burst_t in_burst,
  gni_nbr_if.source  nbr_out
);

  gni_burst_t          slots;
  logic [NUM_DIRS-1:0] pending;
  logic [NUM_DIRS-1:0] pending_next;
  logic [NUM_DIRS-1:0] rest;
  logic [NUM_DIRS-1:0] load_mask;
  logic [1:0]          sel;
  logic                take;
  logic                is_last;

  always_comb begin
    sel = '0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (pending[i]) sel = 2'(i);
    end
    rest = pending;
    rest[sel] = 1'b0;
    is_last = (rest == '0);
    for (int i = 0; i < NUM_DIRS; i++) begin
      load_mask[i] = in_burst[i].valid;
    end
  end

  assign take     = nbr_out.valid && nbr_out.ready;
  // A new burst is taken once the current one has gone or is going now.
  assign in_ready = (pending == '0) || (take && is_last);

  always_comb begin
    pending_next = pending;
    if (in_ready) begin
      pending_next = in_valid ? load_mask : '0;
    end else if (take) begin
      pending_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      slots <= in_burst;
    end
  end

  assign nbr_out.valid           = (pending != '0);
  assign nbr_out.neighbour_index = slots[sel].index;
  assign nbr_out.to_reservoir    = slots[sel].res;
  assign nbr_out.direction       = slots[sel].dir;
  assign nbr_out.last            = is_last;

endmodule

// ===== sim/grid_neighbour_index_unit_test.sv =====
// ----------------------------------------------------------------------------
// grid_neighbour_index_unit_test: self-checking bench for the neighbour unit
// A short table of directed cells is followed by random phases, each under
// its own grid size and boundary mode. Every neighbour result is compared
// with an expectation from the bench's own neighbour calculation, or with a
// value typed into the table where it is obvious.
// ----------------------------------------------------------------------------
module grid_neighbour_index_unit_test;
  import gni_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED      = 38;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 120;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    index_t neighbour_index;
    logic   to_reservoir;
    dir_t   direction;
    logic   last;
  } nbr_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     value;
    coord_t               col;
    coord_t               row;
    logic [2:0]           n_typed;
    nbr_result_t [3:0]    typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_write_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gni_cell_if cell_ch ();
  gni_nbr_if  nbr_ch ();

  grid_neighbour_index_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cell_in      (cell_ch),
    .nbr_out      (nbr_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6ns clk = ~clk;

  // Shadow copy of the configuration, already clamped as the block sees it.
  int    grid_cols = MAX_SIDE;
  int    grid_rows = MAX_SIDE;
  mode_t grid_mode = MODE_PERIODIC;

  nbr_result_t pending_neighbours[$];
  nbr_result_t oldest_neighbour;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          src_gap = 6;
  int          snk_gap = 49;
  stim_row_t   directed_rows [N_DIRECTED];

  function automatic int clamp_side(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic nbr_result_t make_result(input int idx, input bit res, input dir_t d,
                                              input bit lst);
    nbr_result_t r;
    r.neighbour_index = res ? '0 : index_t'(idx);
    r.to_reservoir    = res;
    r.direction       = d;
    r.last            = lst;
    return r;
  endfunction

  // Distances are doubled so that the cell centres land on integers.
  function automatic bit in_circle(input int nx, input int ny);
    int a, b, rad;
    a   = grid_cols - 2 * nx - 1;
    b   = grid_cols - 2 * ny - 1;
    rad = (grid_cols - 1) / 2;
    return a * a + b * b <= 4 * rad * rad;
  endfunction

  function automatic void predict_neighbours(input coord_t c, input coord_t r);
    int x, y, w, h, nx, ny;
    bit out_of_grid;
    nbr_result_t burst[$];
    w = grid_cols;
    h = grid_rows;
    x = (int'(c) >= w) ? w - 1 : int'(c);
    y = (int'(r) >= h) ? h - 1 : int'(r);
    case (grid_mode)
      MODE_PERIODIC: begin
        burst = {burst, make_result(((y + h - 1) % h) * w + x, 1'b0, DIR_NORTH, 1'b0)};
        burst = {burst, make_result(y * w + (x + w - 1) % w, 1'b0, DIR_WEST, 1'b0)};
        burst = {burst, make_result(((y + 1) % h) * w + x, 1'b0, DIR_SOUTH, 1'b0)};
        burst = {burst, make_result(y * w + (x + 1) % w, 1'b0, DIR_EAST, 1'b0)};
      end
      MODE_DISSIPATE: begin
        burst = {burst, make_result(y * w + x - 1, x == 0, DIR_WEST, 1'b0)};
        burst = {burst, make_result(y * w + x + 1, x == w - 1, DIR_EAST, 1'b0)};
        burst = {burst, make_result((y - 1) * w + x, y == 0, DIR_NORTH, 1'b0)};
        burst = {burst, make_result((y + 1) * w + x, y == h - 1, DIR_SOUTH, 1'b0)};
      end
      MODE_WALL: begin
        if (x != 0) burst = {burst, make_result(y * w + x - 1, 1'b0, DIR_WEST, 1'b0)};
        burst = {burst, make_result(y * w + x + 1, x == w - 1, DIR_EAST, 1'b0)};
        if (y != 0) burst = {burst, make_result((y - 1) * w + x, 1'b0, DIR_NORTH, 1'b0)};
        burst = {burst, make_result((y + 1) * w + x, y == h - 1, DIR_SOUTH, 1'b0)};
      end
      default: begin
        for (int d = 0; d < NUM_DIRS; d++) begin
          nx = x + ((d == DIR_EAST) ? 1 : (d == DIR_WEST) ? -1 : 0);
          ny = y + ((d == DIR_SOUTH) ? 1 : (d == DIR_NORTH) ? -1 : 0);
          out_of_grid = nx < 0 || ny < 0 || nx >= w || ny >= h;
          burst = {burst, make_result(ny * w + nx, out_of_grid || !in_circle(nx, ny),
                                      dir_t'(d), 1'b0)};
        end
      end
    endcase
    burst[burst.size() - 1].last = 1'b1;
    pending_neighbours = {pending_neighbours, burst};
  endfunction

  function automatic stim_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    stim_row_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.value   = val;
    return s;
  endfunction

  function automatic stim_row_t typed_row(input coord_t c, input coord_t r, input int n,
                                          input nbr_result_t t0, input nbr_result_t t1,
                                          input nbr_result_t t2, input nbr_result_t t3);
    stim_row_t s;
    s          = '0;
    s.col      = c;
    s.row      = r;
    s.n_typed  = 3'(n);
    s.typed[0] = t0;
    s.typed[1] = t1;
    s.typed[2] = t2;
    s.typed[3] = t3;
    return s;
  endfunction

  function automatic stim_row_t cell_row(input coord_t c, input coord_t r);
    return typed_row(c, r, 0, '0, '0, '0, '0);
  endfunction

  function automatic logic [CFG_W-1:0] pick_side();
    case ($urandom_range(0, 5))
      0:       return CFG_W'($urandom_range(1, 4));
      1:       return CFG_W'($urandom_range(5, 32));
      2:       return CFG_W'($urandom_range(33, 255));
      3:       return CFG_W'(MAX_SIDE);
      4:       return '0;
      default: return CFG_W'($urandom_range(MAX_SIDE + 1, 511));
    endcase
  endfunction

  function automatic coord_t pick_coord(input int side);
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return coord_t'($urandom_range(0, side - 1));
    if (k == 8) return ($urandom_range(0, 1) != 0) ? coord_t'(0) : coord_t'(side - 1);
    return coord_t'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_cell(input coord_t c, input coord_t r, input int n_typed,
                           input nbr_result_t [3:0] typed);
    while ($urandom_range(0, 99) < src_gap) begin
      cell_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.col   <= c;
    cell_ch.row   <= r;
    do @(posedge clk); while (!cell_ch.ready);
    if (n_typed == 0) predict_neighbours(c, r);
    else for (int i = 0; i < n_typed; i++) pending_neighbours = {pending_neighbours, typed[i]};
    @(negedge clk);
  endtask

  task automatic settle();
    cell_ch.valid <= 1'b0;
    while (pending_neighbours.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:    grid_cols = clamp_side(val);
      REG_GRID_HEIGHT:   grid_rows = clamp_side(val);
      REG_BOUNDARY_MODE: grid_mode = mode_t'(val[1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus long hold-offs at a few points so
  // that the pipeline fills and the cell channel stalls.
  initial begin
    int stall_left;
    int hold_done;
    stall_left = 0;
    hold_done  = 0;
    nbr_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && hold_done < 3 && results_seen >= 150 + 550 * hold_done) begin
        stall_left = LONG_HOLD;
        hold_done++;
      end
      if (stall_left > 0) begin
        stall_left--;
        nbr_ch.ready <= 1'b0;
      end else begin
        nbr_ch.ready <= ($urandom_range(0, 99) >= snk_gap);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && nbr_ch.valid && nbr_ch.ready) begin
      results_seen++;
      if (pending_neighbours.size() == 0) begin
        $error("unexpected neighbour request: index %0d direction %0d",
               nbr_ch.neighbour_index, nbr_ch.direction);
        mismatch_count++;
      end else begin
        oldest_neighbour = pending_neighbours.pop_front();
        if (nbr_ch.neighbour_index !== oldest_neighbour.neighbour_index) begin
          $error("neighbour_index: expected %0d, got %0d",
                 oldest_neighbour.neighbour_index, nbr_ch.neighbour_index);
          mismatch_count++;
        end
        if (nbr_ch.to_reservoir !== oldest_neighbour.to_reservoir) begin
          $error("to_reservoir: expected %0d, got %0d",
                 oldest_neighbour.to_reservoir, nbr_ch.to_reservoir);
          mismatch_count++;
        end
        if (nbr_ch.direction !== oldest_neighbour.direction) begin
          $error("direction: expected %0d, got %0d",
                 oldest_neighbour.direction, nbr_ch.direction);
          mismatch_count++;
        end
        if (nbr_ch.last !== oldest_neighbour.last) begin
          $error("last: expected %0d, got %0d", oldest_neighbour.last, nbr_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] side_w, side_h;
    rst           <= 1'b1;
    cell_ch.valid <= 1'b0;
    cell_ch.col   <= '0;
    cell_ch.row   <= '0;
    cfg_write_en  <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;

    directed_rows = '{
      // Reset grid is 256 by 256, periodic: the corners wrap to the far edges.
      typed_row(8'd0, 8'd0, 4,
                make_result(65280, 1'b0, DIR_NORTH, 1'b0),
                make_result(255, 1'b0, DIR_WEST, 1'b0),
                make_result(256, 1'b0, DIR_SOUTH, 1'b0),
                make_result(1, 1'b0, DIR_EAST, 1'b1)),
      typed_row(8'd255, 8'd255, 4,
                make_result(65279, 1'b0, DIR_NORTH, 1'b0),
                make_result(65534, 1'b0, DIR_WEST, 1'b0),
                make_result(255, 1'b0, DIR_SOUTH, 1'b0),
                make_result(65280, 1'b0, DIR_EAST, 1'b1)),
      // Zero sides act as one, so every coordinate folds onto the only cell.
      cfg_row(REG_GRID_WIDTH, 9'd0),
      cfg_row(REG_GRID_HEIGHT, 9'd0),
      typed_row(8'd200, 8'd100, 4,
                make_result(0, 1'b0, DIR_NORTH, 1'b0),
                make_result(0, 1'b0, DIR_WEST, 1'b0),
                make_result(0, 1'b0, DIR_SOUTH, 1'b0),
                make_result(0, 1'b0, DIR_EAST, 1'b1)),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_DISSIPATE)),
      typed_row(8'd5, 8'd5, 4,
                make_result(0, 1'b1, DIR_WEST, 1'b0),
                make_result(0, 1'b1, DIR_EAST, 1'b0),
                make_result(0, 1'b1, DIR_NORTH, 1'b0),
                make_result(0, 1'b1, DIR_SOUTH, 1'b1)),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_WALL)),
      typed_row(8'd0, 8'd0, 2,
                make_result(0, 1'b1, DIR_EAST, 1'b0),
                make_result(0, 1'b1, DIR_SOUTH, 1'b1), '0, '0),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_CIRCULAR)),
      typed_row(8'd9, 8'd3, 4,
                make_result(0, 1'b1, DIR_NORTH, 1'b0),
                make_result(0, 1'b1, DIR_WEST, 1'b0),
                make_result(0, 1'b1, DIR_SOUTH, 1'b0),
                make_result(0, 1'b1, DIR_EAST, 1'b1)),
      // Oversized sides clamp to the maximum.
      cfg_row(REG_GRID_WIDTH, 9'd511),
      cfg_row(REG_GRID_HEIGHT, 9'd300),
      cell_row(8'd0, 8'd0),
      cell_row(8'd128, 8'd128),
      cell_row(8'd255, 8'd0),
      cell_row(8'd0, 8'd127),
      cfg_row(REG_UNUSED, 9'h1FF),
      cell_row(8'd128, 8'd0),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_DISSIPATE)),
      cell_row(8'd0, 8'd0),
      cell_row(8'd255, 8'd255),
      cell_row(8'd17, 8'd200),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_WALL)),
      cell_row(8'd0, 8'd0),
      cell_row(8'd255, 8'd0),
      cell_row(8'd0, 8'd255),
      cell_row(8'd100, 8'd100),
      cfg_row(REG_GRID_WIDTH, 9'd7),
      cfg_row(REG_GRID_HEIGHT, 9'd5),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_CIRCULAR)),
      cell_row(8'd3, 8'd2),
      cell_row(8'd0, 8'd0),
      cell_row(8'd6, 8'd4),
      cell_row(8'd255, 8'd255),
      cfg_row(REG_BOUNDARY_MODE, CFG_W'(MODE_PERIODIC)),
      cell_row(8'd0, 8'd0),
      cell_row(8'd6, 8'd4)
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        push_cell(directed_rows[i].col, directed_rows[i].row,
                  int'(directed_rows[i].n_typed), directed_rows[i].typed);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0:       begin side_w = CFG_W'(MAX_SIDE); side_h = CFG_W'(MAX_SIDE); end
        1:       begin side_w = 9'd1;             side_h = 9'd200;           end
        2:       begin side_w = CFG_W'(MAX_SIDE); side_h = 9'd1;             end
        3:       begin side_w = 9'd0;             side_h = 9'd511;           end
        default: begin side_w = pick_side();      side_h = pick_side();      end
      endcase
      write_reg(REG_GRID_WIDTH, side_w);
      write_reg(REG_GRID_HEIGHT, side_h);
      // Only the low two bits select the mode; the rest are random filler.
      write_reg(REG_BOUNDARY_MODE, {(CFG_W - 2)'($urandom_range(0, 127)), 2'(p % 4)});
      write_reg(REG_UNUSED, CFG_W'($urandom));
      if (p < 4) begin
        src_gap = 6;
        snk_gap = 49;
      end else if (p < 8) begin
        src_gap = 49;
        snk_gap = 6;
      end else begin
        src_gap = 0;
        snk_gap = 0;
      end
      repeat (ITEMS_PER_PHASE) push_cell(pick_coord(grid_cols), pick_coord(grid_rows), 0, '0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
